FILE: rtl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// shared types and constants for the timer table block
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam int NUM_TIMERS_DEF = 32;
    localparam int MAX_RESULTS    = 32;
    localparam int CNT_W          = 6;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    typedef enum logic [2:0] {
        FN_TICK  = 3'd0,
        FN_ALLOC = 3'd1,
        FN_FREE  = 3'd2,
        FN_BIND  = 3'd3,
        FN_ARM   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        EV_ACK        = 2'd0,
        EV_GRANTED    = 2'd1,
        EV_ALLOC_FAIL = 2'd2,
        EV_EXPIRED    = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ACK,
        S_ALLOC,
        S_TICK_CHK,
        S_SCAN_RD,
        S_SCAN_EVAL,
        S_FLUSH
    } state_t;

endpackage

FILE: rtl/mtt_req_if.sv
// ----------------------------------------------------------------------------
// mtt_req_if
// request channel: one operation per beat
// ----------------------------------------------------------------------------
interface mtt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [4:0]  timer_index;
    logic [31:0] delay;
    logic [3:0]  dest_tag;
    logic [7:0]  payload;

    modport source (
        output valid, func, timer_index, delay, dest_tag, payload,
        input  ready
    );
    modport sink (
        input  valid, func, timer_index, delay, dest_tag, payload,
        output ready
    );
endinterface

FILE: rtl/mtt_rsp_if.sv
// ----------------------------------------------------------------------------
// mtt_rsp_if
// response channel: one result per beat
// ----------------------------------------------------------------------------
interface mtt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [4:0] slot;
    logic [3:0] out_tag;
    logic [7:0] out_data;
    logic       last;

    modport source (
        output valid, event_res, slot, out_tag, out_data, last,
        input  ready
    );
    modport sink (
        input  valid, event_res, slot, out_tag, out_data, last,
        output ready
    );
endinterface

FILE: rtl/multi_timer_table.sv
// ----------------------------------------------------------------------------
// multi_timer_table
// table of software timers with a free-running tick count and a tracked
// earliest deadline; expiries are reported one beat per slot
// ----------------------------------------------------------------------------
//
//  channel | dir | beat carries
//  --------+-----+-----------------------------------------------------------
//  req     | in  | func, timer_index, delay, dest_tag, payload
//  rsp     | out | event_res, slot, out_tag, out_data, last
//
//  free, bind, arm and unknown ops pass through exec and ack; alloc walks
//  the slots from 0 up to the first free one; a tick that misses the
//  deadline goes through exec, the deadline check and ack, a tick that
//  scans reads then evaluates each slot in turn (registered read of the
//  deadline/tag/data memories) and ends with a flush beat
//  no clearing pass after reset: slot status lives in flops cleared at once
//  req is taken only when the sequencer is idle; a full rsp register stalls
//  the sequencer wherever it has a beat to hand over
//
module multi_timer_table
    import mtt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    mtt_req_if.sink      req,
    mtt_rsp_if.source    rsp
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    // sequencer
    state_t state_reg, state_next;

    // captured request
    logic [2:0]  func_reg;
    logic [4:0]  idx_reg;
    logic [31:0] delay_reg;
    logic [3:0]  tag_reg;
    logic [7:0]  data_reg;

    // timer state
    logic [31:0]           tick_reg, tick_next;
    logic [31:0]           nd_reg, nd_next;       // earliest armed deadline
    logic [NUM_TIMERS-1:0] used_reg, used_next;   // allocated or armed
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;

    // slot memories, undefined until written
    logic [31:0] dl_mem   [NUM_TIMERS];
    logic [3:0]  tag_mem  [NUM_TIMERS];
    logic [7:0]  data_mem [NUM_TIMERS];
    logic [31:0] rd_dl_reg;
    logic [3:0]  rd_tag_reg;
    logic [7:0]  rd_data_reg;

    // scan walker
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // expiry held back until we know whether it is the final one
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_slot_reg, pend_slot_next;
    logic [3:0]       pend_tag_reg, pend_tag_next;
    logic [7:0]       pend_data_reg, pend_data_next;

    // output register
    logic       ov_reg, ov_next;
    logic [1:0] oev_reg, oev_next;
    logic [4:0] oslot_reg, oslot_next;
    logic [3:0] otag_reg, otag_next;
    logic [7:0] odata_reg, odata_next;
    logic       olast_reg, olast_next;

    logic             out_free;
    logic             idx_ok;
    logic [IDX_W-1:0] widx;
    logic [31:0]      dl_sum;
    logic             dl_we, bind_we;

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = ov_reg;
    assign rsp.event_res = oev_reg;
    assign rsp.slot      = oslot_reg;
    assign rsp.out_tag   = otag_reg;
    assign rsp.out_data  = odata_reg;
    assign rsp.last      = olast_reg;

    // room for a new beat in the output register
    assign out_free = !ov_reg || rsp.ready;
    assign idx_ok   = ({2'b00, idx_reg} < 7'(NUM_TIMERS));
    assign widx     = IDX_W'(idx_reg);
    // arm deadline, wraps mod 2^32
    assign dl_sum   = delay_reg + tick_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg  <= req.func;
            idx_reg   <= req.timer_index;
            delay_reg <= req.delay;
            tag_reg   <= req.dest_tag;
            data_reg  <= req.payload;
        end
    end

    // slot memories: one write port, one registered read at the walker
    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dl_mem[widx] <= dl_sum;
        end
        if (bind_we)
        begin
            tag_mem[widx]  <= tag_reg;
            data_mem[widx] <= data_reg;
        end
        rd_dl_reg   <= dl_mem[ptr_reg];
        rd_tag_reg  <= tag_mem[ptr_reg];
        rd_data_reg <= data_mem[ptr_reg];
    end

    // state register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tick_reg  <= '0;
            nd_reg    <= ALL_ONES;
            used_reg  <= '0;
            armed_reg <= '0;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            nd_reg    <= nd_next;
            used_reg  <= used_next;
            armed_reg <= armed_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        pend_data_reg <= pend_data_next;
        oev_reg       <= oev_next;
        oslot_reg     <= oslot_next;
        otag_reg      <= otag_next;
        odata_reg     <= odata_next;
        olast_reg     <= olast_next;
    end

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        nd_next        = nd_reg;
        used_next      = used_reg;
        armed_next     = armed_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        pend_tag_next  = pend_tag_reg;
        pend_data_next = pend_data_reg;
        ov_next        = ov_reg && !rsp.ready;
        oev_next       = oev_reg;
        oslot_next     = oslot_reg;
        otag_next      = otag_reg;
        odata_next     = odata_reg;
        olast_next     = olast_reg;
        dl_we          = 1'b0;
        bind_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                ptr_next   = '0;
                state_next = S_ACK;
                case (func_reg)
                    FN_TICK:
                    begin
                        tick_next  = tick_reg + 32'd1;
                        state_next = S_TICK_CHK;
                    end
                    FN_ALLOC:
                    begin
                        state_next = S_ALLOC;
                    end
                    FN_FREE:
                    begin
                        if (idx_ok)
                        begin
                            used_next[widx]  = 1'b0;
                            armed_next[widx] = 1'b0;
                        end
                    end
                    FN_BIND:
                    begin
                        bind_we = idx_ok;
                    end
                    FN_ARM:
                    begin
                        if (idx_ok)
                        begin
                            dl_we            = 1'b1;
                            used_next[widx]  = 1'b1;
                            armed_next[widx] = 1'b1;
                            if (nd_reg > dl_sum)
                            begin
                                nd_next = dl_sum;
                            end
                        end
                    end
                    default:
                    begin
                        // unknown op, acknowledged only
                    end
                endcase
            end

            S_ACK:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oev_next   = EV_ACK;
                    oslot_next = '0;
                    otag_next  = '0;
                    odata_next = '0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // walk slots until the lowest free one
            S_ALLOC:
            begin
                if (!used_reg[ptr_reg])
                begin
                    if (out_free)
                    begin
                        used_next[ptr_reg] = 1'b1;
                        ov_next    = 1'b1;
                        oev_next   = EV_GRANTED;
                        oslot_next = 5'(ptr_reg);
                        otag_next  = '0;
                        odata_next = '0;
                        olast_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (ptr_reg == LAST_IDX)
                begin
                    if (out_free)
                    begin
                        ov_next    = 1'b1;
                        oev_next   = EV_ALLOC_FAIL;
                        oslot_next = '0;
                        otag_next  = '0;
                        odata_next = '0;
                        olast_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end

            // deadline reached: start a full scan, else plain ack
            S_TICK_CHK:
            begin
                if (nd_reg > tick_reg)
                begin
                    state_next = S_ACK;
                end
                else
                begin
                    nd_next    = ALL_ONES;
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_SCAN_RD;
                end
            end

            // memory read of slot ptr lands in rd_*_reg
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EVAL;
            end

            S_SCAN_EVAL:
            begin
                if (armed_reg[ptr_reg] && rd_dl_reg <= tick_reg
                    && cnt_reg < CNT_W'(MAX_RESULTS))
                begin
                    // expiry: hand on the held one first, if any
                    if (!pend_reg || out_free)
                    begin
                        if (pend_reg)
                        begin
                            ov_next    = 1'b1;
                            oev_next   = EV_EXPIRED;
                            oslot_next = 5'(pend_slot_reg);
                            otag_next  = pend_tag_reg;
                            odata_next = pend_data_reg;
                            olast_next = 1'b0;
                        end
                        armed_next[ptr_reg] = 1'b0;
                        cnt_next       = cnt_reg + CNT_W'(1);
                        pend_next      = 1'b1;
                        pend_slot_next = ptr_reg;
                        pend_tag_next  = rd_tag_reg;
                        pend_data_next = rd_data_reg;
                        ptr_next       = ptr_reg + IDX_W'(1);
                        state_next     = (ptr_reg == LAST_IDX) ? S_FLUSH : S_SCAN_RD;
                    end
                end
                else
                begin
                    if (armed_reg[ptr_reg] && nd_reg > rd_dl_reg)
                    begin
                        nd_next = rd_dl_reg;
                    end
                    ptr_next   = ptr_reg + IDX_W'(1);
                    state_next = (ptr_reg == LAST_IDX) ? S_FLUSH : S_SCAN_RD;
                end
            end

            // final beat of the tick: held expiry or a plain ack
            S_FLUSH:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    olast_next = 1'b1;
                    if (pend_reg)
                    begin
                        oev_next   = EV_EXPIRED;
                        oslot_next = 5'(pend_slot_reg);
                        otag_next  = pend_tag_reg;
                        odata_next = pend_data_reg;
                    end
                    else
                    begin
                        oev_next   = EV_ACK;
                        oslot_next = '0;
                        otag_next  = '0;
                        odata_next = '0;
                    end
                    pend_next  = 1'b0;
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
